// ===== hw/rtl/kvmr_pkg.sv =====
`timescale 1ns / 1ps

package kvmr_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = KEY_W + VALUE_W;

    localparam int CMD_W    = 3;
    localparam int RANK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_UPDATE     = 3'd1,
        CMD_INS_OR_UPD = 3'd2,
        CMD_ERASE      = 3'd3,
        CMD_CONTAINS   = 3'd4,
        CMD_GET_KEY    = 3'd5,
        CMD_GET_RANK   = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

endpackage

// ===== hw/rtl/kvmr_if.sv =====
`timescale 1ns / 1ps

interface kvmr_req_if;
    logic                          valid;
    logic                          ready;
    logic [kvmr_pkg::CMD_W-1:0]    cmd;
    logic [kvmr_pkg::KEY_W-1:0]    key;
    logic [kvmr_pkg::VALUE_W-1:0]  value;
    logic [kvmr_pkg::RANK_W-1:0]   rank;

    modport source (output valid, cmd, key, value, rank, input ready);
    modport sink   (input valid, cmd, key, value, rank, output ready);
endinterface

interface kvmr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [kvmr_pkg::STATUS_W-1:0] status;
    logic [kvmr_pkg::KEY_W-1:0]    key_out;
    logic [kvmr_pkg::VALUE_W-1:0]  value_out;
    logic [kvmr_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, status, key_out, value_out, entry_count, input ready);
    modport sink   (input valid, status, key_out, value_out, entry_count, output ready);
endinterface

// ===== hw/rtl/kvmr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module kvmr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/key_value_map_with_rank_top.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake   | Payload
// --------+-----+-------------+-------------------------------------------
// req     | in  | valid/ready | cmd[2:0] key[31:0] value[31:0] rank[5:0]
// rsp     | out | valid/ready | status[2:0] key_out[31:0] value_out[31:0]
//         |     |             | entry_count[6:0]
//
// One command at a time. Key-based commands sweep the slot RAM once. Insert
// and erase then shift the rank-order RAM, a read step and a write step per
// moved entry, then a commit step. get_by_rank reads order RAM then slot
// RAM. No-op and rank out of range go straight to the response. req is
// ready again in the cycle rsp goes valid.
// Reset clears the valid bits and the count at once; no clearing pass.
// A finished result waits in the rsp register while the next command is
// taken; the engine stalls only when a second result is ready before the
// first transfer has gone out.
module key_value_map_with_rank_top (
    input  logic       clk,
    input  logic       rst_n,
    kvmr_req_if.sink   req,
    kvmr_rsp_if.source rsp
);

    localparam int SLOT_W  = kvmr_pkg::SLOT_W;
    localparam int CNT_W   = kvmr_pkg::CNT_W;
    localparam int KEY_W   = kvmr_pkg::KEY_W;
    localparam int VALUE_W = kvmr_pkg::VALUE_W;
    localparam int ENTRY_W = kvmr_pkg::ENTRY_W;
    localparam int RANK_W  = kvmr_pkg::RANK_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_RANK_ORD,
        S_RANK_SLOT,
        S_RANK_DATA,
        S_RESP
    } state_t;

    state_t state_reg;

    // latched command
    kvmr_pkg::cmd_t          cmd_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic [RANK_W-1:0]       rank_reg;

    // sweep pipeline: address stage and compare stage
    logic [SLOT_W:0]         scan_idx_reg;
    logic                    chk_vld_reg;
    logic [SLOT_W-1:0]       chk_slot_reg;

    // sweep results
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hit_slot_reg;
    logic [VALUE_W-1:0]      hit_val_reg;
    logic [CNT_W-1:0]        lt_cnt_reg;     // held keys below key_reg = rank position
    logic                    free_found_reg;
    logic [SLOT_W-1:0]       free_slot_reg;

    // order-RAM shift pointer
    logic [CNT_W-1:0]        idx_reg;

    // store state
    logic [kvmr_pkg::CAPACITY-1:0] valid_reg;
    logic [CNT_W-1:0]        count_reg;

    // pending result
    kvmr_pkg::status_t       res_status_reg;
    logic [KEY_W-1:0]        res_key_reg;
    logic [VALUE_W-1:0]      res_val_reg;

    // output register
    logic                    rsp_valid_reg;
    kvmr_pkg::status_t       rsp_status_reg;
    logic [KEY_W-1:0]        rsp_key_reg;
    logic [VALUE_W-1:0]      rsp_val_reg;
    logic [kvmr_pkg::COUNT_W-1:0] rsp_count_reg;

    // RAM ports
    logic                    slot_we;
    logic [SLOT_W-1:0]       slot_waddr;
    logic [ENTRY_W-1:0]      slot_wdata;
    logic [SLOT_W-1:0]       slot_raddr;
    logic [ENTRY_W-1:0]      slot_rdata;

    logic                    ord_we;
    logic [SLOT_W-1:0]       ord_waddr;
    logic [SLOT_W-1:0]       ord_wdata;
    logic [SLOT_W-1:0]       ord_raddr;
    logic [SLOT_W-1:0]       ord_rdata;

    // slot RAM: {key, value} per slot
    kvmr_ram #(
        .DEPTH (kvmr_pkg::CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // order RAM: entry i holds the slot of the key with rank i
    kvmr_ram #(
        .DEPTH (kvmr_pkg::CAPACITY),
        .WIDTH (SLOT_W)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    logic [KEY_W-1:0]   slot_rkey;
    logic [VALUE_W-1:0] slot_rval;
    logic               chk_live;
    logic               chk_hit;
    logic               chk_lt;
    logic               is_erase;
    logic               rank_ok;
    logic [CNT_W-1:0]   shift_src;
    logic               rsp_free;

    assign slot_rkey = slot_rdata[ENTRY_W-1:VALUE_W];
    assign slot_rval = slot_rdata[VALUE_W-1:0];
    assign chk_live  = chk_vld_reg && valid_reg[chk_slot_reg];
    assign chk_hit   = chk_live && (slot_rkey == key_reg);
    assign chk_lt    = chk_live && (slot_rkey < key_reg);
    assign is_erase  = (cmd_reg == kvmr_pkg::CMD_ERASE);
    assign rank_ok   = ({{CNT_W{1'b0}}, rank_reg} < {{RANK_W{1'b0}}, count_reg});
    // insert moves entries up (read below), erase moves them down (read above)
    assign shift_src = is_erase ? (idx_reg + CNT_W'(1)) : (idx_reg - CNT_W'(1));
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.key_out     = rsp_key_reg;
    assign rsp.value_out   = rsp_val_reg;
    assign rsp.entry_count = rsp_count_reg;

    // RAM access control; where a read and a write address the same entry in
    // the same cycle, the sequencer does not use that read data
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = hit_slot_reg;
        slot_wdata = {key_reg, value_reg};
        slot_raddr = scan_idx_reg[SLOT_W-1:0];
        ord_we     = 1'b0;
        ord_waddr  = idx_reg[SLOT_W-1:0];
        ord_wdata  = ord_rdata;
        ord_raddr  = shift_src[SLOT_W-1:0];
        unique case (state_reg)
            S_DECIDE:
            begin
                if (hit_reg && (cmd_reg == kvmr_pkg::CMD_UPDATE ||
                                cmd_reg == kvmr_pkg::CMD_INS_OR_UPD))
                begin
                    slot_we = 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                ord_we = 1'b1;
            end
            S_FINISH:
            begin
                if (!is_erase)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = free_slot_reg;
                    ord_we     = 1'b1;
                    ord_waddr  = lt_cnt_reg[SLOT_W-1:0];
                    ord_wdata  = free_slot_reg;
                end
            end
            S_RANK_ORD:
            begin
                ord_raddr = SLOT_W'(rank_reg);
            end
            S_RANK_SLOT:
            begin
                slot_raddr = ord_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= kvmr_pkg::CMD_NOP;
            key_reg        <= '0;
            value_reg      <= '0;
            rank_reg       <= '0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            chk_slot_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            hit_val_reg    <= '0;
            lt_cnt_reg     <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            idx_reg        <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            res_status_reg <= kvmr_pkg::ST_OK;
            res_key_reg    <= '0;
            res_val_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= kvmr_pkg::ST_OK;
            rsp_key_reg    <= '0;
            rsp_val_reg    <= '0;
            rsp_count_reg  <= '0;
        end
        else
        begin
            // S_RESP reloads the register itself when the transfer goes out
            if (rsp_valid_reg && rsp.ready && state_reg != S_RESP)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg        <= kvmr_pkg::cmd_t'(req.cmd);
                        key_reg        <= req.key;
                        value_reg      <= req.value;
                        rank_reg       <= req.rank;
                        scan_idx_reg   <= '0;
                        chk_vld_reg    <= 1'b0;
                        hit_reg        <= 1'b0;
                        lt_cnt_reg     <= '0;
                        free_found_reg <= 1'b0;
                        res_key_reg    <= '0;
                        res_val_reg    <= '0;
                        unique case (kvmr_pkg::cmd_t'(req.cmd))
                            kvmr_pkg::CMD_GET_RANK:
                            begin
                                // range check needs the new rank; compare directly
                                if ({{CNT_W{1'b0}}, req.rank} < {{RANK_W{1'b0}}, count_reg})
                                begin
                                    res_status_reg <= kvmr_pkg::ST_OK;
                                    state_reg      <= S_RANK_ORD;
                                end
                                else
                                begin
                                    res_status_reg <= kvmr_pkg::ST_RANGE;
                                    state_reg      <= S_RESP;
                                end
                            end
                            kvmr_pkg::CMD_NOP:
                            begin
                                res_status_reg <= kvmr_pkg::ST_OK;
                                state_reg      <= S_RESP;
                            end
                            default:
                            begin
                                res_status_reg <= kvmr_pkg::ST_OK;
                                state_reg      <= S_SCAN;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (scan_idx_reg < (SLOT_W+1)'(kvmr_pkg::CAPACITY))
                    begin
                        scan_idx_reg <= scan_idx_reg + (SLOT_W+1)'(1);
                        chk_vld_reg  <= 1'b1;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    chk_slot_reg <= scan_idx_reg[SLOT_W-1:0];

                    if (chk_hit)
                    begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= chk_slot_reg;
                        hit_val_reg  <= slot_rval;
                    end
                    if (chk_lt)
                    begin
                        lt_cnt_reg <= lt_cnt_reg + CNT_W'(1);
                    end
                    if (chk_vld_reg && !valid_reg[chk_slot_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= chk_slot_reg;
                    end
                    if (chk_vld_reg && chk_slot_reg == SLOT_W'(kvmr_pkg::CAPACITY - 1))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    unique case (cmd_reg)
                        kvmr_pkg::CMD_INSERT,
                        kvmr_pkg::CMD_INS_OR_UPD:
                        begin
                            if (hit_reg)
                            begin
                                if (cmd_reg == kvmr_pkg::CMD_INSERT)
                                begin
                                    res_status_reg <= kvmr_pkg::ST_PRESENT;
                                end
                                state_reg <= S_RESP;
                            end
                            else if (!free_found_reg)
                            begin
                                res_status_reg <= kvmr_pkg::ST_FULL;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                // open a hole at the new key's rank position
                                idx_reg <= count_reg;
                                if (count_reg > lt_cnt_reg)
                                begin
                                    state_reg <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                        end
                        kvmr_pkg::CMD_UPDATE:
                        begin
                            if (!hit_reg)
                            begin
                                res_status_reg <= kvmr_pkg::ST_ABSENT;
                            end
                            state_reg <= S_RESP;
                        end
                        kvmr_pkg::CMD_ERASE:
                        begin
                            if (!hit_reg)
                            begin
                                res_status_reg <= kvmr_pkg::ST_ABSENT;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                // close the gap left at the key's rank position
                                idx_reg <= lt_cnt_reg;
                                if ((lt_cnt_reg + CNT_W'(1)) < count_reg)
                                begin
                                    state_reg <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                        end
                        kvmr_pkg::CMD_CONTAINS:
                        begin
                            if (!hit_reg)
                            begin
                                res_status_reg <= kvmr_pkg::ST_ABSENT;
                            end
                            state_reg <= S_RESP;
                        end
                        kvmr_pkg::CMD_GET_KEY:
                        begin
                            if (hit_reg)
                            begin
                                res_val_reg <= hit_val_reg;
                            end
                            else
                            begin
                                res_status_reg <= kvmr_pkg::ST_ABSENT;
                            end
                            state_reg <= S_RESP;
                        end
                        kvmr_pkg::CMD_GET_RANK,
                        kvmr_pkg::CMD_NOP:
                        begin
                            state_reg <= S_RESP;
                        end
                    endcase
                end

                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end

                S_SHIFT_WR:
                begin
                    if (is_erase)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        if ((idx_reg + CNT_W'(2)) < count_reg)
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg - CNT_W'(1);
                        if ((idx_reg - CNT_W'(1)) > lt_cnt_reg)
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (is_erase)
                    begin
                        valid_reg[hit_slot_reg] <= 1'b0;
                        count_reg               <= count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        valid_reg[free_slot_reg] <= 1'b1;
                        count_reg                <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_RESP;
                end

                S_RANK_ORD:
                begin
                    state_reg <= S_RANK_SLOT;
                end

                S_RANK_SLOT:
                begin
                    state_reg <= S_RANK_DATA;
                end

                S_RANK_DATA:
                begin
                    res_key_reg <= slot_rkey;
                    res_val_reg <= slot_rval;
                    state_reg   <= S_RESP;
                end

                S_RESP:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= res_status_reg;
                        rsp_key_reg    <= res_key_reg;
                        rsp_val_reg    <= res_val_reg;
                        rsp_count_reg  <= kvmr_pkg::COUNT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // entry count always matches the number of live slots
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count does not match live slots");

    // only the commit step changes the entry count and the valid bits
    a_count_only_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_FINISH |=> $stable(count_reg) && $stable(valid_reg))
        else $error("store changed outside commit");

    // a rank lookup only starts inside the held range
    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RANK_ORD |-> rank_ok)
        else $error("rank lookup past entry count");

    // an accepted command always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("accepted command dropped");
`endif

endmodule

// ===== dv/key_value_map_with_rank_top_test.sv =====
`timescale 1ns / 1ps

// Checks the ranked key/value store: commands go in on req, one result per
// command comes back on rsp. A local copy of the slot store predicts each
// result at the moment its command transfers, and the rsp monitor compares
// every transfer against the oldest prediction.
module key_value_map_with_rank_top_test;

    import kvmr_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int POOL_SIZE  = 40;
    // Limit on the whole run; the slowest command is a shifting insert/erase
    // plus a full stall burst on each side.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Quiet cycles after the last result, covering one worst-case command.
    localparam int TAIL_CYCLES = 4 * CAPACITY + 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t              status;
        logic [KEY_W-1:0]     key_out;
        logic [VALUE_W-1:0]   value_out;
        logic [COUNT_W-1:0]   entry_count;
    } map_rsp_t;

    logic clk;
    logic rst_n;

    kvmr_req_if req ();
    kvmr_rsp_if rsp ();

    key_value_map_with_rank_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow of the slot store.
    logic                 map_valid [CAPACITY];
    logic [KEY_W-1:0]     map_key   [CAPACITY];
    logic [VALUE_W-1:0]   map_value [CAPACITY];
    int unsigned          map_count;

    map_rsp_t             pending_rsp [$];
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];

    int  mismatch_count;
    int  cycle_count;
    // When low, neither side inserts idle bursts.
    bit  idle_on;

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int find_key(input logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int s = 0; s < CAPACITY; s++)
            if (hit < 0 && map_valid[s] && map_key[s] == k)
                hit = s;
        return hit;
    endfunction

    // Lowest free slot takes the new entry; full store is reported.
    function automatic status_t store_new(input logic [KEY_W-1:0] k,
                                          input logic [VALUE_W-1:0] v);
        int s;
        s = 0;
        while (s < CAPACITY && map_valid[s])
            s++;
        if (s == CAPACITY)
            return ST_FULL;
        map_valid[s] = 1'b1;
        map_key[s]   = k;
        map_value[s] = v;
        map_count++;
        return ST_OK;
    endfunction

    function automatic map_rsp_t predict_map_op(input cmd_t c,
                                                input logic [KEY_W-1:0] k,
                                                input logic [VALUE_W-1:0] v,
                                                input logic [RANK_W-1:0] r);
        map_rsp_t res;
        int       hit;
        int       below;
        bit       found;
        res.status    = ST_OK;
        res.key_out   = '0;
        res.value_out = '0;
        hit = find_key(k);
        case (c)
            CMD_INSERT:
                res.status = (hit >= 0) ? ST_PRESENT : store_new(k, v);
            CMD_UPDATE:
                if (hit >= 0)
                    map_value[hit] = v;
                else
                    res.status = ST_ABSENT;
            CMD_INS_OR_UPD:
                if (hit >= 0)
                    map_value[hit] = v;
                else
                    res.status = store_new(k, v);
            CMD_ERASE:
                if (hit >= 0)
                begin
                    map_valid[hit] = 1'b0;
                    map_count--;
                end
                else
                    res.status = ST_ABSENT;
            CMD_CONTAINS:
                res.status = (hit >= 0) ? ST_OK : ST_ABSENT;
            CMD_GET_KEY:
                if (hit >= 0)
                    res.value_out = map_value[hit];
                else
                    res.status = ST_ABSENT;
            CMD_GET_RANK:
            begin
                res.status = ST_RANGE;
                found = 1'b0;
                if (r < map_count)
                    for (int s = 0; s < CAPACITY; s++)
                    begin
                        if (!found && map_valid[s])
                        begin
                            below = 0;
                            for (int t = 0; t < CAPACITY; t++)
                                if (map_valid[t] && map_key[s] > map_key[t])
                                    below++;
                            if (below == r)
                            begin
                                found         = 1'b1;
                                res.status    = ST_OK;
                                res.key_out   = map_key[s];
                                res.value_out = map_value[s];
                            end
                        end
                    end
            end
            default:
                ;
        endcase
        res.entry_count = map_count[COUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v,
                            input logic [RANK_W-1:0] r);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= c;
        req.key   <= k;
        req.value <= v;
        req.rank  <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // transfer happened at this edge
        pending_rsp.push_back(predict_map_op(c, k, v, r));
    endtask

    // ------------------------------------------------------------------
    // Response monitor and stall generator
    // ------------------------------------------------------------------
    initial
    begin
        int       stall_left;
        map_rsp_t exp_rsp;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected rsp st=%0d key=%h val=%h cnt=%0d",
                                 $realtime, rsp.status, rsp.key_out, rsp.value_out,
                                 rsp.entry_count);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp.status !== exp_rsp.status ||
                        rsp.key_out !== exp_rsp.key_out ||
                        rsp.value_out !== exp_rsp.value_out ||
                        rsp.entry_count !== exp_rsp.entry_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("%0t: rsp mismatch exp st=%0d key=%h val=%h cnt=%0d",
                                     $realtime, exp_rsp.status, exp_rsp.key_out,
                                     exp_rsp.value_out, exp_rsp.entry_count);
                            $display("%0t:              got st=%0d key=%h val=%h cnt=%0d",
                                     $realtime, rsp.status, rsp.key_out,
                                     rsp.value_out, rsp.entry_count);
                        end
                    end
                end
            end
            // stall in random bursts
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] held_key();
        int n;
        logic [KEY_W-1:0] k;
        n = $urandom_range(0, map_count - 1);
        k = '0;
        for (int s = 0; s < CAPACITY; s++)
            if (map_valid[s])
            begin
                if (n == 0)
                    k = map_key[s];
                n--;
            end
        return k;
    endfunction

    // held_pct: chance of hitting a key that is in the store right now
    function automatic logic [KEY_W-1:0] pick_key(input int held_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (map_count != 0 && roll < held_pct)
            return held_key();
        if (roll < held_pct + 25)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        if (map_count != 0 && $urandom_range(0, 3) != 0)
            return RANK_W'($urandom_range(0, map_count - 1));
        return RANK_W'($urandom_range(0, 63));
    endfunction

    // One random command; ins_w / era_w weigh inserts and erases (percent).
    task automatic send_random(input int ins_w, input int era_w, input int held_pct);
        int   roll;
        cmd_t c;
        roll = $urandom_range(0, 99);
        if (roll < ins_w)
            c = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_INS_OR_UPD;
        else if (roll < ins_w + era_w)
            c = CMD_ERASE;
        else if (roll < 98)
            c = cmd_t'($urandom_range(0, 6));
        else
            c = CMD_NOP;
        send_cmd(c, pick_key(held_pct), $urandom,
                 (c == CMD_GET_RANK) ? pick_rank() : RANK_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd0);           // empty store
        send_cmd(CMD_ERASE, 32'h5, 32'h0, 6'd0);
        send_cmd(CMD_UPDATE, 32'h5, 32'h1, 6'd0);
        send_cmd(CMD_GET_KEY, 32'h5, 32'h0, 6'd0);
        send_cmd(CMD_CONTAINS, 32'h5, 32'h0, 6'd0);
        send_cmd(CMD_INSERT, 32'h0, 32'h0, 6'd0);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_cmd(CMD_INSERT, 32'h0, 32'h1234_5678, 6'd0);     // already present
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_cmd(CMD_GET_KEY, 32'h0, 32'h0, 6'd0);
        send_cmd(CMD_UPDATE, 32'h0, 32'hA5A5_A5A5, 6'd0);
        send_cmd(CMD_INS_OR_UPD, 32'hFFFF_FFFF, 32'h0, 6'd0); // update path
        send_cmd(CMD_INS_OR_UPD, 32'h8000_0000, 32'h5A5A_5A5A, 6'd0); // insert path
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd0);
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd1);
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd2);
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd3);           // rank == count
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd63);
        send_cmd(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_cmd(CMD_ERASE, 32'h8000_0000, 32'h0, 6'd0);
        send_cmd(CMD_ERASE, 32'h8000_0000, 32'h0, 6'd0);      // now absent
        send_cmd(CMD_GET_RANK, 32'h0, 32'h0, 6'd1);
    endtask

    // Insert-heavy until the store is full, then poke at it with few erases:
    // inserts of absent keys report full, present keys still report present.
    task automatic test_fill_to_capacity();
        while (map_count < CAPACITY)
            send_random(80, 5, 10);
        for (int i = 0; i < 40; i++)
        begin
            if (map_count == CAPACITY && $urandom_range(0, 3) == 0)
                send_cmd(CMD_GET_RANK, 32'h0, $urandom, 6'(CAPACITY - 1));
            else
                send_random(60, 3, 40);
        end
    endtask

    task automatic test_mixed_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            // drift between filling and draining phases
            if ((i / 200) % 2 == 0)
                send_random(30, 15, 50);
            else
                send_random(15, 30, 50);
        end
    endtask

    // Erase-heavy until empty, then twenty commands starting from the empty store.
    task automatic test_drain();
        while (map_count != 0)
            send_random(5, 70, 85);
        for (int i = 0; i < 20; i++)
            send_random(0, 30, 0);
    endtask

    task automatic test_back_to_back(input int n_items);
        idle_on = 1'b0;
        for (int i = 0; i < n_items; i++)
            send_random(25, 20, 50);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        map_count      = 0;
        for (int s = 0; s < CAPACITY; s++)
            map_valid[s] = 1'b0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h1;
        key_pool[3] = 32'h8000_0000;
        key_pool[4] = 32'h7FFF_FFFF;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.cmd   <= CMD_NOP;
        req.key   <= '0;
        req.value <= '0;
        req.rank  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_fill_to_capacity();
        test_mixed_traffic(1150);
        test_drain();
        test_fill_to_capacity();
        test_back_to_back(300);
        req.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
